### rtl/string_key_hash_table_quadratic_probe_core_macros.svh
// Assertion macros for the hash table core checker.
`ifndef STRING_KEY_HASH_TABLE_QUADRATIC_PROBE_CORE_MACROS_SVH
`define STRING_KEY_HASH_TABLE_QUADRATIC_PROBE_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SKH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SKH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/skhqp_pkg.sv
// Package: types, constants and codes for the hash table core.
package skhqp_pkg;
    localparam int TableSlots  = 101;
    localparam int ProbeCount  = 20;
    localparam int MaxKeyChars = 16;
    localparam int HashMult    = 19;
    localparam int ProbeLin    = 23;

    localparam logic [1:0] FUNC_ADD  = 2'd0;
    localparam logic [1:0] FUNC_DEL  = 2'd1;
    localparam logic [1:0] FUNC_FIND = 2'd2;
    localparam logic [1:0] FUNC_READ = 2'd3;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_PRESENT  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_DELETED  = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_FOUND    = 3'd5;
endpackage

### rtl/skhqp_ram.sv
// Generic single-port synchronous RAM with registered read.
module skhqp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/string_key_hash_table_quadratic_probe_core.sv
// Top level: open-addressing string-key hash table with quadratic probing.
//
// Usage:
//  - Drive i_func and the key/slot fields and raise start while busy is low;
//    the request is accepted on that edge and busy rises the next cycle.
//  - Add/delete/find: the key is hashed one character per cycle. The home
//    slot is then reduced mod TABLE_SLOTS by repeated subtraction, scaled
//    by the hash multiplier and reduced again. Then up to PROBE_COUNT
//    probes are made, each an address state and then a registered memory
//    read and compare, and a finishing write state writes the slot when
//    needed. A hit stops the probing.
//  - Read slot: one memory access; the slot is addressed in the read state
//    and the result is registered from the memory output in the address state.
//  - One result per request, shown on the o_ ports for exactly one cycle
//    with o_valid high. busy falls with it, so the next request can be
//    accepted on the edge that ends the result cycle.
//  - The receiver cannot stall; no buffering is needed.
//  - Reset: one clearing pass writes an all-zero word to every slot, with
//    busy high meanwhile.
//  - Slot contents are a single memory word {high, low, length}.
module string_key_hash_table_quadratic_probe_core #(
    parameter int TABLE_SLOTS   = skhqp_pkg::TableSlots,
    parameter int PROBE_COUNT   = skhqp_pkg::ProbeCount,
    parameter int MAX_KEY_CHARS = skhqp_pkg::MaxKeyChars
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [63:0] i_key_chars_low,
    input  logic [63:0] i_key_chars_high,
    input  logic [4:0]  i_key_length,
    input  logic [6:0]  i_slot_index,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [6:0]  o_slot,
    output logic [6:0]  o_occupied_count,
    output logic [63:0] o_slot_chars_low_out,
    output logic [63:0] o_slot_chars_high_out,
    output logic [4:0]  o_slot_length_out
);
    import skhqp_pkg::*;

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int PW = $clog2(PROBE_COUNT + 1);
    localparam int MW = 133;
    // hash sum bound: 255*136*19 < 2^20
    localparam int SW = 20;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_HASH, S_MOD, S_ADDR, S_CMP, S_WRITE, S_READ
    } t_state;

    t_state             r_state;
    logic [AW-1:0]      r_clr;
    logic [1:0]         r_func;
    logic [63:0]        r_lo, r_hi;
    logic [4:0]         r_len;
    logic [4:0]         r_ci;
    logic [SW-1:0]      r_sum;
    logic [AW-1:0]      r_home;
    logic [PW-1:0]      r_j;
    logic [AW:0]        r_off;      // j*j+23*j mod N, kept incrementally
    logic [AW:0]        r_step;     // 2j+24 mod N
    logic [AW-1:0]      r_pos;
    logic               r_have_free;
    logic [AW-1:0]      r_free;
    logic [CW-1:0]      r_count;
    logic [6:0]         r_idx;

    logic               n_we;
    logic [AW-1:0]      n_addr;
    logic [MW-1:0]      n_wdata;
    logic [MW-1:0]      w_rdata;

    skhqp_ram #(.WIDTH(MW), .DEPTH(TABLE_SLOTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (n_we),
        .i_addr (n_addr),
        .i_wdata(n_wdata),
        .o_rdata(w_rdata)
    );

    logic [4:0]  w_len;
    logic [63:0] w_lo, w_hi, w_lomask, w_himask;
    logic [4:0]  w_rlen;
    logic [7:0]  w_char;
    logic [AW+1:0] w_p;
    logic [AW+1:0] w_off2, w_step2;
    logic [AW:0] w_offn;
    logic        w_match;
    logic        w_commit;

    always_comb begin
        w_len = (i_key_length > 5'(MAX_KEY_CHARS)) ? 5'(MAX_KEY_CHARS) : i_key_length;
        w_lomask = (w_len >= 5'd8) ? '1 : ((64'd1 << {w_len[2:0], 3'b000}) - 64'd1);
        w_himask = (w_len >= 5'd16) ? '1 :
                   (w_len > 5'd8) ? ((64'd1 << {w_len[2:0], 3'b000}) - 64'd1) : '0;
        w_lo = i_key_chars_low & w_lomask;
        w_hi = i_key_chars_high & w_himask;
        w_char = r_ci[3] ? r_hi[{r_ci[2:0], 3'b000} +: 8] : r_lo[{r_ci[2:0], 3'b000} +: 8];
        w_rlen = w_rdata[4:0];
        w_match = (w_rlen == r_len) && (w_rdata[68:5] == r_lo) && (w_rdata[132:69] == r_hi);
        w_off2 = {1'b0, r_off} + {1'b0, r_step};
        w_offn = (w_off2 >= (AW+2)'(TABLE_SLOTS)) ?
                 (AW+1)'(w_off2 - (AW+2)'(TABLE_SLOTS)) : w_off2[AW:0];
        // next probe position: home plus the next offset
        w_p = {2'b00, r_home} + {1'b0, w_offn};
        w_step2 = {1'b0, r_step} + (AW+2)'(2);
        // r_len nonzero after a finished probe sequence marks a real write
        w_commit = (r_len != 5'd0) && (r_ci == 5'd31);
    end

    // memory port control
    always_comb begin
        n_we = 1'b0;
        n_addr = r_pos;
        n_wdata = {r_hi, r_lo, r_len};
        case (r_state)
            S_CLEAR: begin
                n_we = 1'b1;
                n_addr = r_clr;
                n_wdata = '0;
            end
            S_WRITE: begin
                n_we = w_commit && (r_func == FUNC_ADD || r_func == FUNC_DEL);
                n_addr = r_free;
                if (r_func == FUNC_DEL) begin
                    n_addr = r_pos;
                    n_wdata = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_count <= '0;
            busy <= 1'b1;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    o_valid <= 1'b0;
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(TABLE_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                        busy <= 1'b0;
                    end
                end
                S_IDLE: begin
                    o_valid <= 1'b0;
                    if (start) begin
                        busy <= 1'b1;
                        r_func <= i_func;
                        r_lo <= w_lo;
                        r_hi <= w_hi;
                        r_len <= w_len;
                        r_idx <= i_slot_index;
                        r_ci <= '0;
                        r_sum <= '0;
                        r_pos <= i_slot_index[AW-1:0];
                        if (i_func == FUNC_READ) begin
                            if (32'(i_slot_index) < 32'(TABLE_SLOTS)) begin
                                r_state <= S_READ;
                            end else begin
                                r_state <= S_WRITE;
                            end
                        end else if (w_len == 5'd0) begin
                            r_state <= S_WRITE;
                        end else begin
                            r_state <= S_HASH;
                        end
                    end
                end
                S_HASH: begin
                    o_valid <= 1'b0;
                    r_sum <= r_sum + SW'(w_char) * SW'(r_ci + 5'd1);
                    r_ci <= r_ci + 5'd1;
                    if (r_ci + 5'd1 == r_len) begin
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    o_valid <= 1'b0;
                    if (r_sum >= SW'(TABLE_SLOTS * 16)) begin
                        r_sum <= r_sum - SW'(TABLE_SLOTS * 16);
                    end else if (r_sum >= SW'(TABLE_SLOTS)) begin
                        r_sum <= r_sum - SW'(TABLE_SLOTS);
                    end else begin
                        // r_sum now holds sum mod N; multiply by 19 and reduce again
                        if (r_ci != 5'd31) begin
                            r_sum <= SW'(r_sum * HashMult);
                            r_ci <= 5'd31;
                        end else begin
                            r_home <= r_sum[AW-1:0];
                            r_pos <= r_sum[AW-1:0];
                            r_off <= '0;
                            r_step <= (AW+1)'(24 % TABLE_SLOTS);
                            r_j <= '0;
                            r_have_free <= 1'b0;
                            r_state <= S_ADDR;
                        end
                    end
                end
                S_ADDR: begin
                    if (r_func == FUNC_READ) begin
                        o_valid <= 1'b1;
                        o_status <= ST_FOUND;
                        o_slot <= r_idx;
                        o_occupied_count <= 7'(r_count);
                        o_slot_length_out <= w_rlen;
                        o_slot_chars_low_out <= (w_rlen != 5'd0) ? w_rdata[68:5] : '0;
                        o_slot_chars_high_out <= (w_rlen != 5'd0) ? w_rdata[132:69] : '0;
                        r_state <= S_IDLE;
                        busy <= 1'b0;
                    end else begin
                        o_valid <= 1'b0;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    o_valid <= w_match && (r_func != FUNC_DEL);
                    if (!r_have_free && w_rlen == 5'd0) begin
                        r_have_free <= 1'b1;
                        r_free <= r_pos;
                    end
                    r_off <= w_offn;
                    r_step <= (w_step2 >= (AW+2)'(TABLE_SLOTS)) ?
                              (AW+1)'(w_step2 - (AW+2)'(TABLE_SLOTS)) : w_step2[AW:0];
                    if (w_match) begin
                        o_status <= (r_func == FUNC_ADD) ? ST_PRESENT :
                                    (r_func == FUNC_DEL) ? ST_DELETED : ST_FOUND;
                        o_slot <= 7'(r_pos);
                        o_occupied_count <= 7'(r_count);
                        o_slot_chars_low_out <= '0;
                        o_slot_chars_high_out <= '0;
                        o_slot_length_out <= '0;
                        if (r_func == FUNC_DEL) begin
                            r_state <= S_WRITE;
                            r_len <= 5'd1;
                        end else begin
                            r_state <= S_IDLE;
                            busy <= 1'b0;
                        end
                    end else if (r_j + PW'(1) == PW'(PROBE_COUNT)) begin
                        r_state <= S_WRITE;
                        r_len <= (r_func == FUNC_ADD && (r_have_free || w_rlen == 5'd0)) ?
                                 r_len : 5'd0;
                    end else begin
                        r_j <= r_j + PW'(1);
                        r_pos <= (w_p >= (AW+2)'(TABLE_SLOTS)) ?
                                 AW'(w_p - (AW+2)'(TABLE_SLOTS)) : w_p[AW-1:0];
                        r_state <= S_ADDR;
                    end
                end
                S_WRITE: begin
                    o_valid <= 1'b1;
                    o_slot_chars_low_out <= '0;
                    o_slot_chars_high_out <= '0;
                    o_slot_length_out <= '0;
                    if (w_commit && r_func == FUNC_DEL) begin
                        o_status <= ST_DELETED;
                        o_slot <= 7'(r_pos);
                        o_occupied_count <= 7'(r_count - CW'(1));
                        r_count <= r_count - CW'(1);
                    end else if (w_commit && r_func == FUNC_ADD) begin
                        o_status <= ST_INSERTED;
                        o_slot <= 7'(r_free);
                        o_occupied_count <= 7'(r_count + CW'(1));
                        r_count <= r_count + CW'(1);
                    end else begin
                        // full table only after a probed add; else not found
                        o_status <= (r_func == FUNC_ADD && r_ci == 5'd31) ?
                                    ST_FULL : ST_NOTFOUND;
                        o_slot <= '0;
                        o_occupied_count <= 7'(r_count);
                    end
                    r_state <= S_IDLE;
                    busy <= 1'b0;
                end
                S_READ: begin
                    o_valid <= 1'b0;
                    r_state <= S_ADDR;
                    r_func <= FUNC_READ;
                    r_ci <= 5'd0;
                end
                default: begin
                    o_valid <= 1'b0;
                    r_state <= S_IDLE;
                    busy <= 1'b0;
                end
            endcase
        end
    end
endmodule

### rtl/skhqp_checker.sv
// Port-level checker for the hash table core, with its bind.
`include "string_key_hash_table_quadratic_probe_core_macros.svh"
module skhqp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [2:0] o_status,
    input logic [6:0] o_slot,
    input logic [6:0] o_occupied_count
);
    import skhqp_pkg::*;
    `SKH_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `SKH_ASSERT_IMP(a_valid_busy, i_clk, i_rst_n, o_valid, !$past(busy) == 1'b0)
    `SKH_ASSERT_IMP(a_count_max, i_clk, i_rst_n, o_valid, o_occupied_count <= 7'(TableSlots))
    `SKH_ASSERT_IMP(a_status_range, i_clk, i_rst_n, o_valid, o_status <= ST_FOUND)
    `SKH_ASSERT_IMP(a_slot_range, i_clk, i_rst_n, o_valid, o_slot < 7'(TableSlots))
endmodule

bind string_key_hash_table_quadratic_probe_core skhqp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_status(o_status), .o_slot(o_slot),
    .o_occupied_count(o_occupied_count)
);
